/* sv/assert_macros.svh */
// Assertion macros used by the checker file.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while rst is high.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while rst is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

/* sv/hpt_pkg.sv */
// Shared types, constants and helper functions for the point transform.
// Used by every module of the block; depends on nothing.
package hpt_pkg;

   localparam int COORD_W  = 32;
   localparam int NUM_COEF = 16;
   localparam int COEF_AW  = 4;
   localparam int ACC_W    = 50;
   localparam int MUL_W    = 33;
   localparam int PROD_W   = 2 * MUL_W;
   localparam int QUO_W    = 33;
   localparam int CNT_W    = $clog2(QUO_W);

   localparam logic signed [COORD_W-1:0] Q_ONE   = 32'sh0001_0000;
   localparam logic signed [COORD_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [COORD_W-1:0] S32_MIN = 32'sh8000_0000;

   localparam logic signed [ACC_W-1:0] ACC_S32_MAX = ACC_W'(64'sd2147483647);
   localparam logic signed [ACC_W-1:0] ACC_S32_MIN = -ACC_W'(64'sd2147483648);

   localparam logic [1:0] OP_LOAD  = 2'd0;
   localparam logic [1:0] OP_POINT = 2'd1;
   localparam logic [1:0] OP_DIR   = 2'd2;

   typedef struct packed {
      logic [1:0]                opcode;
      logic [COEF_AW-1:0]        coeff_index;
      logic signed [COORD_W-1:0] coeff_value;
      logic signed [COORD_W-1:0] in_x;
      logic signed [COORD_W-1:0] in_y;
      logic signed [COORD_W-1:0] in_z;
   } req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] out_x;
      logic signed [COORD_W-1:0] out_y;
      logic signed [COORD_W-1:0] out_z;
      logic                      divide_error;
   } rsp_type;

   typedef struct packed {
      logic               wr_en;
      logic [COEF_AW-1:0] wr_addr;
      logic [COORD_W-1:0] wr_data;
      logic               rd_en;
      logic [COEF_AW-1:0] rd_addr;
   } mem_req_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAC,
      ST_CHECK,
      ST_DIV,
      ST_SCALE,
      ST_DONE
   } state_type;

   // Diagonal entries of the row-major matrix hold 1.0.
   function automatic logic signed [COORD_W-1:0] identity_coef(logic [COEF_AW-1:0] idx);
      return (idx[1:0] == idx[3:2]) ? Q_ONE : '0;
   endfunction

   function automatic logic signed [COORD_W-1:0] sat_acc(logic signed [ACC_W-1:0] v);
      if (v > ACC_S32_MAX) return S32_MAX;
      else if (v < ACC_S32_MIN) return S32_MIN;
      else return v[COORD_W-1:0];
   endfunction

   // Apply sign to a magnitude and clamp to the 32-bit signed range.
   function automatic logic signed [COORD_W-1:0] sat_mag(logic [PROD_W-1:0] m, logic neg);
      logic [COORD_W-1:0] t;
      t = ~m[COORD_W-1:0] + 32'd1;
      if (neg) return (m > PROD_W'(64'd2147483648)) ? S32_MIN : t;
      else return (m > PROD_W'(64'd2147483647)) ? S32_MAX : m[COORD_W-1:0];
   endfunction

   // Magnitude of the clamped reciprocal.
   function automatic logic [COORD_W-1:0] recip_mag(logic [QUO_W-1:0] q, logic neg);
      if (neg) return (q > QUO_W'(64'd2147483648)) ? 32'h8000_0000 : q[COORD_W-1:0];
      else return (q > QUO_W'(64'd2147483647)) ? 32'h7FFF_FFFF : q[COORD_W-1:0];
   endfunction

endpackage

/* sv/hpt_coef_mem.sv */
// Coefficient store: 16 x 32 synchronous memory, one write and one read port.
// Per-entry valid bits make unwritten entries read as the identity matrix.
// Depends on hpt_pkg.
module hpt_coef_mem (
   input  logic                                clock,
   input  logic                                reset,
   input  hpt_pkg::mem_req_type                req,
   output logic signed [hpt_pkg::COORD_W-1:0]  rd_data
);

   logic [hpt_pkg::COORD_W-1:0] mem_ff [hpt_pkg::NUM_COEF];
   logic [hpt_pkg::NUM_COEF-1:0] vld_ff;
   logic [hpt_pkg::COORD_W-1:0] rd_ff;
   logic                        rd_vld_ff;
   logic [hpt_pkg::COEF_AW-1:0] rd_addr_ff;

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem_ff[req.wr_addr] <= req.wr_data;
      end
      if (req.rd_en) begin
         rd_ff      <= mem_ff[req.rd_addr];
         rd_vld_ff  <= vld_ff[req.rd_addr];
         rd_addr_ff <= req.rd_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (req.wr_en) begin
         vld_ff[req.wr_addr] <= 1'b1;
      end
   end

   assign rd_data = rd_vld_ff ? rd_ff : hpt_pkg::identity_coef(rd_addr_ff);

endmodule

/* sv/hpt_mul.sv */
// Shared registered signed multiplier, 33 x 33 to 66 bits.
// Depends on hpt_pkg for widths.
module hpt_mul (
   input  logic                               clock,
   input  logic signed [hpt_pkg::MUL_W-1:0]   mul_a,
   input  logic signed [hpt_pkg::MUL_W-1:0]   mul_b,
   output logic signed [hpt_pkg::PROD_W-1:0]  mul_p
);

   always_ff @(posedge clock) begin
      mul_p <= mul_a * mul_b;
   end

endmodule

/* sv/hpt_recip.sv */
// Serial reciprocal: quotient of 2^32 by an unsigned divisor, one bit a cycle.
// Restoring division over 33 quotient bits. Depends on hpt_pkg.
module hpt_recip (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [hpt_pkg::ACC_W-1:0]         divisor,
   output logic                              done,
   output logic [hpt_pkg::QUO_W-1:0]         quotient
);

   logic                         busy_ff;
   logic                         done_ff;
   logic [hpt_pkg::CNT_W-1:0]    cnt_ff;
   logic [hpt_pkg::ACC_W:0]      rem_ff;
   logic [hpt_pkg::ACC_W-1:0]    dvs_ff;
   logic [hpt_pkg::QUO_W-1:0]    quo_ff;
   logic [hpt_pkg::ACC_W:0]      trial;
   logic                         fits;
   logic [hpt_pkg::ACC_W:0]      rem_in;

   // Dividend is a single one at the top quotient position.
   always_comb begin
      trial  = {rem_ff[hpt_pkg::ACC_W-1:0],
                (cnt_ff == hpt_pkg::CNT_W'(hpt_pkg::QUO_W - 1))};
      fits   = (trial >= {1'b0, dvs_ff});
      rem_in = fits ? (trial - {1'b0, dvs_ff}) : trial;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && (cnt_ff == '0)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         cnt_ff <= hpt_pkg::CNT_W'(hpt_pkg::QUO_W - 1);
         rem_ff <= '0;
         quo_ff <= '0;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[hpt_pkg::QUO_W-2:0], fits};
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

/* sv/homogeneous_point_transform.sv */
// Homogeneous 4x4 point transform, signed Q16.16; top level.
// Depends on hpt_pkg, hpt_coef_mem, hpt_mul and hpt_recip.
// Usage: items arrive on req_* (valid/stall) as hpt_pkg::req_type; results
// leave on rsp_* as hpt_pkg::rsp_type from an output register. A load
// (opcode 0) writes one coefficient in the cycle it transfers and gives no
// result; opcode 3 is dropped. A point or direction transform walks all 16
// coefficients through the memory and one shared multiplier, then checks w.
// Directions and points with w of exactly 1.0 go straight to the output
// register; points with w of zero give zeros with divide_error. Other points
// add the serial reciprocal (33 quotient bits) and three scaling lanes, each
// through the phases LO, HI and FIN.
// One transform is in flight at a time; req_stall is high from the transfer
// until the result moves to the output register, so a new item is taken the
// cycle after. If the receiver stalls with a result still held, a finished
// transform waits and holds req_stall. Reset (synchronous) restores the
// identity matrix at once through per-entry valid bits and empties the
// output register; no clearing pass is needed.
module homogeneous_point_transform (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  hpt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output hpt_pkg::rsp_type rsp_data
);

   localparam logic [1:0] PH_LO     = 2'd0;
   localparam logic [1:0] PH_HI     = 2'd1;
   localparam logic [1:0] PH_FIN    = 2'd2;
   localparam logic [1:0] LAST_LANE = 2'd2;

   hpt_pkg::state_type state_ff, state_in;

   logic [hpt_pkg::COEF_AW:0]   cnt_ff, cnt_in;
   logic                        s1_vld_ff, s2_vld_ff;
   logic [hpt_pkg::COEF_AW-1:0] s1_idx_ff, s2_idx_ff;
   logic signed [hpt_pkg::COORD_W-1:0] s2_coef_ff;
   logic [1:0]                  scl_ff, scl_in;
   logic [1:0]                  ph_ff, ph_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   hpt_pkg::rsp_type            rsp_data_ff;

   logic                               is_pt_ff;
   logic signed [hpt_pkg::COORD_W-1:0] crd_ff [3];
   logic signed [hpt_pkg::ACC_W-1:0]   acc_ff [4];
   logic signed [hpt_pkg::COORD_W-1:0] res_ff [3];
   logic                               err_ff;
   logic                               wneg_ff;
   logic [hpt_pkg::COORD_W-1:0]        rmag_ff;
   logic [hpt_pkg::PROD_W-1:0]         lo_ff;

   hpt_pkg::mem_req_type               mem_req;
   logic signed [hpt_pkg::COORD_W-1:0] coef_rd;
   logic signed [hpt_pkg::MUL_W-1:0]   mul_a, mul_b;
   logic signed [hpt_pkg::PROD_W-1:0]  mul_p;
   logic                               div_start, div_done;
   logic [hpt_pkg::QUO_W-1:0]          quo;

   logic                               accept_req, start_xf, mac_done, out_free;
   logic                               w_one, w_zero;
   logic [hpt_pkg::ACC_W-1:0]          w_mag, s_mag;
   logic signed [hpt_pkg::COORD_W-1:0] crd_sel;
   logic signed [hpt_pkg::ACC_W-1:0]   addend;
   logic [hpt_pkg::PROD_W-1:0]         m_sum;
   logic                               res_neg;

   hpt_coef_mem u_mem (
      .clock   (clock),
      .reset   (reset),
      .req     (mem_req),
      .rd_data (coef_rd)
   );

   hpt_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .mul_p (mul_p)
   );

   hpt_recip u_recip (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .divisor  (w_mag),
      .done     (div_done),
      .quotient (quo)
   );

   // Handshake, memory port and datapath selects.
   always_comb begin
      req_stall  = (state_ff != hpt_pkg::ST_IDLE);
      accept_req = req_valid && !req_stall;
      start_xf   = accept_req && ((req_data.opcode == hpt_pkg::OP_POINT) ||
                                  (req_data.opcode == hpt_pkg::OP_DIR));

      mem_req.wr_en   = accept_req && (req_data.opcode == hpt_pkg::OP_LOAD);
      mem_req.wr_addr = req_data.coeff_index;
      mem_req.wr_data = req_data.coeff_value;
      mem_req.rd_en   = (state_ff == hpt_pkg::ST_MAC) && !cnt_ff[hpt_pkg::COEF_AW];
      mem_req.rd_addr = cnt_ff[hpt_pkg::COEF_AW-1:0];

      mac_done = (state_ff == hpt_pkg::ST_MAC) && cnt_ff[hpt_pkg::COEF_AW] &&
                 !s1_vld_ff && !s2_vld_ff;
      out_free = !rsp_valid_ff || !rsp_stall;

      w_one  = (acc_ff[3] == hpt_pkg::ACC_W'(hpt_pkg::Q_ONE));
      w_zero = (acc_ff[3] == '0);
      w_mag  = acc_ff[3][hpt_pkg::ACC_W-1] ? hpt_pkg::ACC_W'(-acc_ff[3]) : acc_ff[3];
      s_mag  = acc_ff[0][hpt_pkg::ACC_W-1] ? hpt_pkg::ACC_W'(-acc_ff[0]) : acc_ff[0];
      res_neg = acc_ff[0][hpt_pkg::ACC_W-1] ^ wneg_ff;

      div_start = (state_ff == hpt_pkg::ST_CHECK) && is_pt_ff && !w_one && !w_zero;

      case (s1_idx_ff[3:2])
         2'd0:    crd_sel = crd_ff[0];
         2'd1:    crd_sel = crd_ff[1];
         2'd2:    crd_sel = crd_ff[2];
         default: crd_sel = '0;
      endcase

      if (state_ff == hpt_pkg::ST_SCALE) begin
         mul_a = (ph_ff == PH_LO) ? hpt_pkg::MUL_W'(s_mag[31:0])
                                  : hpt_pkg::MUL_W'(s_mag[hpt_pkg::ACC_W-1:32]);
         mul_b = hpt_pkg::MUL_W'(rmag_ff);
      end else begin
         mul_a = hpt_pkg::MUL_W'(coef_rd);
         mul_b = hpt_pkg::MUL_W'(crd_sel);
      end

      // Translation row adds the coefficient itself, only for points.
      if (s2_idx_ff[3:2] == 2'd3) begin
         addend = is_pt_ff ? hpt_pkg::ACC_W'(s2_coef_ff) : '0;
      end else begin
         addend = mul_p[hpt_pkg::ACC_W+15:16];
      end

      m_sum = (hpt_pkg::PROD_W'($unsigned(mul_p)) << 16) + (lo_ff >> 16);
   end

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      scl_in       = scl_ff;
      ph_in        = ph_ff;
      rsp_valid_in = rsp_valid_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         hpt_pkg::ST_IDLE: begin
            if (start_xf) begin
               state_in = hpt_pkg::ST_MAC;
               cnt_in   = '0;
            end
         end
         hpt_pkg::ST_MAC: begin
            if (mem_req.rd_en) begin
               cnt_in = cnt_ff + 1'b1;
            end
            if (mac_done) begin
               state_in = hpt_pkg::ST_CHECK;
            end
         end
         hpt_pkg::ST_CHECK: begin
            scl_in = '0;
            ph_in  = PH_LO;
            state_in = div_start ? hpt_pkg::ST_DIV : hpt_pkg::ST_DONE;
         end
         hpt_pkg::ST_DIV: begin
            if (div_done) begin
               state_in = hpt_pkg::ST_SCALE;
            end
         end
         hpt_pkg::ST_SCALE: begin
            if (ph_ff == PH_FIN) begin
               ph_in  = PH_LO;
               scl_in = scl_ff + 1'b1;
               if (scl_ff == LAST_LANE) begin
                  state_in = hpt_pkg::ST_DONE;
               end
            end else begin
               ph_in = ph_ff + 1'b1;
            end
         end
         hpt_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = hpt_pkg::ST_IDLE;
            end
         end
         default: state_in = hpt_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hpt_pkg::ST_IDLE;
         cnt_ff       <= '0;
         s1_vld_ff    <= 1'b0;
         s2_vld_ff    <= 1'b0;
         scl_ff       <= '0;
         ph_ff        <= PH_LO;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         s1_vld_ff    <= mem_req.rd_en;
         s2_vld_ff    <= s1_vld_ff;
         scl_ff       <= scl_in;
         ph_ff        <= ph_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_idx_ff  <= cnt_ff[hpt_pkg::COEF_AW-1:0];
      s2_idx_ff  <= s1_idx_ff;
      s2_coef_ff <= coef_rd;

      if (start_xf) begin
         is_pt_ff  <= (req_data.opcode == hpt_pkg::OP_POINT);
         crd_ff[0] <= req_data.in_x;
         crd_ff[1] <= req_data.in_y;
         crd_ff[2] <= req_data.in_z;
      end

      // Clear on start, accumulate per column, rotate during scaling.
      if (start_xf) begin
         for (int c = 0; c < 4; c++) begin
            acc_ff[c] <= '0;
         end
      end else if ((state_ff == hpt_pkg::ST_SCALE) && (ph_ff == PH_FIN)) begin
         acc_ff[0] <= acc_ff[1];
         acc_ff[1] <= acc_ff[2];
      end else if (s2_vld_ff) begin
         for (int c = 0; c < 4; c++) begin
            if (s2_idx_ff[1:0] == 2'(c)) begin
               acc_ff[c] <= acc_ff[c] + addend;
            end
         end
      end

      if (state_ff == hpt_pkg::ST_CHECK) begin
         wneg_ff <= acc_ff[3][hpt_pkg::ACC_W-1];
         if (!is_pt_ff || w_one) begin
            res_ff[0] <= hpt_pkg::sat_acc(acc_ff[0]);
            res_ff[1] <= hpt_pkg::sat_acc(acc_ff[1]);
            res_ff[2] <= hpt_pkg::sat_acc(acc_ff[2]);
            err_ff    <= 1'b0;
         end else if (w_zero) begin
            res_ff[0] <= '0;
            res_ff[1] <= '0;
            res_ff[2] <= '0;
            err_ff    <= 1'b1;
         end else begin
            err_ff    <= 1'b0;
         end
      end

      if (div_done) begin
         rmag_ff <= hpt_pkg::recip_mag(quo, wneg_ff);
      end

      if ((state_ff == hpt_pkg::ST_SCALE) && (ph_ff == PH_HI)) begin
         lo_ff <= mul_p;
      end

      // Results shift in at the top; x ends up in slot 0.
      if ((state_ff == hpt_pkg::ST_SCALE) && (ph_ff == PH_FIN)) begin
         res_ff[0] <= res_ff[1];
         res_ff[1] <= res_ff[2];
         res_ff[2] <= hpt_pkg::sat_mag(m_sum, res_neg);
      end

      if ((state_ff == hpt_pkg::ST_DONE) && out_free) begin
         rsp_data_ff.out_x        <= res_ff[0];
         rsp_data_ff.out_y        <= res_ff[1];
         rsp_data_ff.out_z        <= res_ff[2];
         rsp_data_ff.divide_error <= err_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* sv/hpt_checker.sv */
// Port-level checker for the point transform, bound to the top level.
// Depends on hpt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module hpt_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input hpt_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input hpt_pkg::rsp_type rsp_data
);

   logic xf_xfer, load_xfer, err_out, out_zero;

   assign xf_xfer   = req_valid && !req_stall &&
                      ((req_data.opcode == hpt_pkg::OP_POINT) ||
                       (req_data.opcode == hpt_pkg::OP_DIR));
   assign load_xfer = req_valid && !req_stall && (req_data.opcode == hpt_pkg::OP_LOAD);
   assign err_out   = rsp_valid && rsp_data.divide_error;
   assign out_zero  = (rsp_data.out_x == 0) && (rsp_data.out_y == 0) &&
                      (rsp_data.out_z == 0);

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

   `ASSERT_IMPL(a_err_zero, clock, reset, err_out, out_zero)

   `ASSERT_NEXT(a_xf_busy, clock, reset, xf_xfer, req_stall)

   `ASSERT_NEXT(a_load_free, clock, reset, load_xfer, !req_stall)

   `ASSERT_NEXT(a_reset_quiet, clock, 1'b0, reset, !rsp_valid && !req_stall)

endmodule

bind homogeneous_point_transform hpt_checker u_hpt_checker (.*);
